[sv/pccd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the pointer click/drag classifier.
// Register map, item codes and register reset values; no dependencies.
package pccd_pkg;

  // APB register map (byte address = 4 * index)
  localparam int unsigned CFG_ADDR_BITS = 4;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_DRAG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROXIMITY      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRAG_THRESHOLD = 2'd2;

  // Item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CANCEL = 1'b1;

  // Register reset values
  localparam logic        DRAG_ENABLE_RESET    = 1'b1;
  localparam logic [15:0] PROXIMITY_RESET      = 16'd150;
  localparam logic [15:0] DRAG_THRESHOLD_RESET = 16'd5;
  localparam logic [31:0] PROXIMITY_SQ_RESET   = 32'd22500;
  localparam logic [31:0] DRAG_THRESHOLD_SQ_RESET = 32'd25;

endpackage

[sv/pccd_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the pointer click/drag classifier: one pointer sample
// or cancel request per transaction. No dependencies.
interface pccd_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] cursor_x;
  logic signed [COORD_BITS-1:0] cursor_y;
  logic                         left_down;
  logic                         right_down;
  logic signed [COORD_BITS-1:0] box_x;
  logic signed [COORD_BITS-1:0] box_y;
  logic        [COORD_BITS-2:0] box_w;
  logic        [COORD_BITS-2:0] box_h;
  logic                         clear_events;

  modport source (
    output valid, func, cursor_x, cursor_y, left_down, right_down,
           box_x, box_y, box_w, box_h, clear_events,
    input  ready
  );

  modport sink (
    input  valid, func, cursor_x, cursor_y, left_down, right_down,
           box_x, box_y, box_w, box_h, clear_events,
    output ready
  );
endinterface

[sv/pccd_out_if.sv]
`timescale 1ns / 1ps
// Result channel of the pointer click/drag classifier: one result per
// transaction. No dependencies.
interface pccd_out_if #(
  parameter int COORD_BITS = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [COORD_BITS:0]     delta_x;
  logic signed [COORD_BITS:0]     delta_y;
  logic signed [COORD_BITS:0]     rel_x;
  logic signed [COORD_BITS:0]     rel_y;
  logic        [2*COORD_BITS:0]   dist_sq;
  logic                           hovering;
  logic                           near;
  logic                           dragging;
  logic                           left_clicked;
  logic                           right_clicked;
  logic signed [COORD_BITS:0]     grab_x;
  logic signed [COORD_BITS:0]     grab_y;

  modport source (
    output valid, delta_x, delta_y, rel_x, rel_y, dist_sq, hovering, near,
           dragging, left_clicked, right_clicked, grab_x, grab_y,
    input  ready
  );

  modport sink (
    input  valid, delta_x, delta_y, rel_x, rel_y, dist_sq, hovering, near,
           dragging, left_clicked, right_clicked, grab_x, grab_y,
    output ready
  );
endinterface

[sv/pointer_click_drag_classifier.sv]
`timescale 1ns / 1ps
// Pointer click/drag classifier top level.
// Depends on pccd_pkg, pccd_in_if and pccd_out_if.

// One transaction is accepted every clock cycle while the sink takes results.
// A sample goes into an input register and is evaluated in combinational logic:
// position delta, rectangle offsets, two squares for the centre distance and
// two for the drag travel. When it advances, it lands in the result register,
// from which the result is offered to the sink.
// The result register holds while the sink stalls. The input register then
// holds its sample, and input ready stays low until the result is taken.
// Input ready follows output ready in the same cycle, so no cycle is lost when
// a stall ends. Interaction state (last position, button history, press
// tracking, drag and latched clicks) updates when an item moves from the input
// register to the result register. The squares of proximity_px and
// drag_threshold_px are computed when they are written; write the registers
// only while no transaction is in flight.
module pointer_click_drag_classifier #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pccd_in_if.sink                            in_ch,
  pccd_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pccd_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [pccd_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [pccd_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import pccd_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int W    = C + 1;        // delta / relative width
  localparam int MW   = C + 1;        // centre offset magnitude width
  localparam int DW   = 2 * C + 1;    // dist_sq width
  localparam int CMPW = (2 * MW + 1 > 32) ? 2 * MW + 1 : 32;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic        drag_en_q;
  logic [15:0] prox_q;
  logic [15:0] thr_q;
  logic [31:0] prox_sq_q;
  logic [31:0] thr_sq_q;
  logic        cfg_wr;
  logic [CFG_IDX_BITS-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_en_q <= DRAG_ENABLE_RESET;
      prox_q    <= PROXIMITY_RESET;
      thr_q     <= DRAG_THRESHOLD_RESET;
      prox_sq_q <= PROXIMITY_SQ_RESET;
      thr_sq_q  <= DRAG_THRESHOLD_SQ_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DRAG_ENABLE: begin
          drag_en_q <= pwdata[0];
        end
        REG_PROXIMITY: begin
          prox_q    <= pwdata[15:0];
          prox_sq_q <= {16'd0, pwdata[15:0]} * {16'd0, pwdata[15:0]};
        end
        REG_DRAG_THRESHOLD: begin
          thr_q    <= pwdata[15:0];
          thr_sq_q <= {16'd0, pwdata[15:0]} * {16'd0, pwdata[15:0]};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DRAG_ENABLE:    prdata = {31'd0, drag_en_q};
      REG_PROXIMITY:      prdata = {16'd0, prox_q};
      REG_DRAG_THRESHOLD: prdata = {16'd0, thr_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                in_valid_q;
  logic                func_q;
  logic signed [C-1:0] cx_q, cy_q, bx_q, by_q;
  logic        [C-2:0] bw_q, bh_q;
  logic                ld_q, rd_q, clr_q;
  logic                out_valid_q;
  logic                advance;
  logic                in_take;

  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= in_ch.func;
      cx_q   <= in_ch.cursor_x;
      cy_q   <= in_ch.cursor_y;
      ld_q   <= in_ch.left_down;
      rd_q   <= in_ch.right_down;
      bx_q   <= in_ch.box_x;
      by_q   <= in_ch.box_y;
      bw_q   <= in_ch.box_w;
      bh_q   <= in_ch.box_h;
      clr_q  <= in_ch.clear_events;
    end
  end

  // ---------------------------------------------------------------------
  // Interaction state
  // ---------------------------------------------------------------------
  logic signed [C-1:0] last_x_q, last_y_q, press_x_q, press_y_q;
  logic signed [W-1:0] offset_x_q, offset_y_q;
  logic primed_q, prev_left_q, prev_right_q, track_q, drag_q, left_ev_q, right_ev_q;

  logic signed [C-1:0] last_x_d, last_y_d, press_x_d, press_y_d;
  logic signed [W-1:0] offset_x_d, offset_y_d;
  logic primed_d, prev_left_d, prev_right_d, track_d, drag_d, left_ev_d, right_ev_d;

  // ---------------------------------------------------------------------
  // Per-sample arithmetic
  // ---------------------------------------------------------------------
  logic signed [W-1:0]  cx_w, cy_w, bx_w, by_w;
  logic signed [W-1:0]  dx, dy, rx, ry, cen_x, cen_y, tx, ty;
  logic signed [MW:0]   ex, ey;
  logic [MW-1:0]        mag_ex, mag_ey;
  logic [C-1:0]         mag_tx, mag_ty;
  logic [2*MW-1:0]      sq_ex, sq_ey;
  logic [2*MW:0]        sum_e;
  logic [2*C-1:0]       sq_tx, sq_ty;
  logic [DW-1:0]        sum_t;
  logic [DW-1:0]        dsq;
  logic                 hov, nr, travel_ok;
  logic                 is_cancel;

  assign is_cancel = (func_q == FUNC_CANCEL);

  assign cx_w = {cx_q[C-1], cx_q};
  assign cy_w = {cy_q[C-1], cy_q};
  assign bx_w = {bx_q[C-1], bx_q};
  assign by_w = {by_q[C-1], by_q};

  assign dx = primed_q ? cx_w - {last_x_q[C-1], last_x_q} : '0;
  assign dy = primed_q ? cy_w - {last_y_q[C-1], last_y_q} : '0;
  assign rx = cx_w - bx_w;
  assign ry = cy_w - by_w;

  // Centre offset, halves rounded down
  assign cen_x = bx_w + $signed({3'b000, bw_q[C-2:1]});
  assign cen_y = by_w + $signed({3'b000, bh_q[C-2:1]});
  assign ex    = {cx_w[W-1], cx_w} - {cen_x[W-1], cen_x};
  assign ey    = {cy_w[W-1], cy_w} - {cen_y[W-1], cen_y};
  assign mag_ex = ex[MW] ? MW'(-ex) : MW'(ex);
  assign mag_ey = ey[MW] ? MW'(-ey) : MW'(ey);
  assign sq_ex  = {{MW{1'b0}}, mag_ex} * {{MW{1'b0}}, mag_ex};
  assign sq_ey  = {{MW{1'b0}}, mag_ey} * {{MW{1'b0}}, mag_ey};
  assign sum_e  = {1'b0, sq_ex} + {1'b0, sq_ey};
  // Saturate at the all-ones value of dist_sq
  assign dsq    = (|sum_e[2*MW:DW]) ? {DW{1'b1}} : sum_e[DW-1:0];

  assign hov = !rx[W-1] && (rx < $signed({2'b00, bw_q}))
            && !ry[W-1] && (ry < $signed({2'b00, bh_q}));
  assign nr  = CMPW'(dsq) <= CMPW'(prox_sq_q);

  // Travel from the press point
  assign tx     = cx_w - {press_x_q[C-1], press_x_q};
  assign ty     = cy_w - {press_y_q[C-1], press_y_q};
  assign mag_tx = tx[C] ? C'(-tx) : C'(tx);
  assign mag_ty = ty[C] ? C'(-ty) : C'(ty);
  assign sq_tx  = {{C{1'b0}}, mag_tx} * {{C{1'b0}}, mag_tx};
  assign sq_ty  = {{C{1'b0}}, mag_ty} * {{C{1'b0}}, mag_ty};
  assign sum_t  = {1'b0, sq_tx} + {1'b0, sq_ty};
  assign travel_ok = CMPW'(sum_t) >= CMPW'(thr_sq_q);

  always_comb begin
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    primed_d     = primed_q;
    prev_left_d  = prev_left_q;
    prev_right_d = prev_right_q;
    track_d      = track_q;
    drag_d       = drag_q;
    press_x_d    = press_x_q;
    press_y_d    = press_y_q;
    offset_x_d   = offset_x_q;
    offset_y_d   = offset_y_q;
    left_ev_d    = clr_q ? 1'b0 : left_ev_q;
    right_ev_d   = clr_q ? 1'b0 : right_ev_q;

    if (is_cancel) begin
      track_d    = 1'b0;
      drag_d     = 1'b0;
      left_ev_d  = 1'b0;
      right_ev_d = 1'b0;
    end else begin
      last_x_d = cx_q;
      last_y_d = cy_q;
      primed_d = 1'b1;
      if (drag_en_q) begin
        if (ld_q) begin
          if (!prev_left_q && !drag_q && hov && !track_q) begin
            track_d    = 1'b1;
            press_x_d  = cx_q;
            press_y_d  = cy_q;
            offset_x_d = rx;
            offset_y_d = ry;
          end else if (track_q && !drag_q && travel_ok) begin
            drag_d = 1'b1;
          end
        end else begin
          // release without drag latches a left click
          if (track_q && !drag_q) begin
            left_ev_d = 1'b1;
          end
          drag_d  = 1'b0;
          track_d = 1'b0;
        end
      end
      if (!rd_q && prev_right_q && hov) begin
        right_ev_d = 1'b1;
      end
      prev_left_d  = ld_q;
      prev_right_d = rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q     <= '0;
      last_y_q     <= '0;
      primed_q     <= 1'b0;
      prev_left_q  <= 1'b0;
      prev_right_q <= 1'b0;
      track_q      <= 1'b0;
      drag_q       <= 1'b0;
      press_x_q    <= '0;
      press_y_q    <= '0;
      offset_x_q   <= '0;
      offset_y_q   <= '0;
      left_ev_q    <= 1'b0;
      right_ev_q   <= 1'b0;
    end else if (advance) begin
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
      primed_q     <= primed_d;
      prev_left_q  <= prev_left_d;
      prev_right_q <= prev_right_d;
      track_q      <= track_d;
      drag_q       <= drag_d;
      press_x_q    <= press_x_d;
      press_y_q    <= press_y_d;
      offset_x_q   <= offset_x_d;
      offset_y_q   <= offset_y_d;
      left_ev_q    <= left_ev_d;
      right_ev_q   <= right_ev_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic signed [W-1:0] o_dx_q, o_dy_q, o_rx_q, o_ry_q, o_gx_q, o_gy_q;
  logic [DW-1:0]       o_dsq_q;
  logic                o_hov_q, o_near_q, o_drag_q, o_lclk_q, o_rclk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      o_dx_q   <= is_cancel ? '0 : dx;
      o_dy_q   <= is_cancel ? '0 : dy;
      o_rx_q   <= is_cancel ? '0 : rx;
      o_ry_q   <= is_cancel ? '0 : ry;
      o_dsq_q  <= is_cancel ? '0 : dsq;
      o_hov_q  <= !is_cancel && hov;
      o_near_q <= !is_cancel && nr;
      o_drag_q <= drag_d;
      o_lclk_q <= left_ev_d;
      o_rclk_q <= right_ev_d;
      o_gx_q   <= offset_x_d;
      o_gy_q   <= offset_y_d;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.delta_x       = o_dx_q;
  assign out_ch.delta_y       = o_dy_q;
  assign out_ch.rel_x         = o_rx_q;
  assign out_ch.rel_y         = o_ry_q;
  assign out_ch.dist_sq       = o_dsq_q;
  assign out_ch.hovering      = o_hov_q;
  assign out_ch.near          = o_near_q;
  assign out_ch.dragging      = o_drag_q;
  assign out_ch.left_clicked  = o_lclk_q;
  assign out_ch.right_clicked = o_rclk_q;
  assign out_ch.grab_x        = o_gx_q;
  assign out_ch.grab_y        = o_gy_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_drag_needs_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drag_q |-> track_q)
    else $error("drag active without press tracking");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready) |=> $stable(last_x_q) && $stable(track_q))
    else $error("interaction state moved while result stalled");

  a_cancel_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_cancel) |=> !drag_q && !track_q && !left_ev_q && !right_ev_q)
    else $error("cancel left interaction state set");

  a_sample_primes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_cancel) |=> primed_q && out_valid_q)
    else $error("sample did not prime position history");

endmodule

[bench/pccd_scoreboard.sv]
`timescale 1ns / 1ps
// Scoreboard for the pointer click/drag classifier bench: follows register
// writes, predicts one status per accepted transaction and compares each result.
// Depends on pccd_pkg, pccd_in_if and pccd_out_if.
module pccd_scoreboard #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pccd_in_if                                 in_mon,
  pccd_out_if                                out_mon,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [pccd_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [pccd_pkg::CFG_DATA_BITS-1:0] pwdata,
  output int                                 failures_o,
  output int                                 pending_o
);
  import pccd_pkg::*;

  localparam int W = COORD_BITS;
  localparam longint DIST_MAX = (longint'(1) << (2 * W + 1)) - 1;

  typedef struct packed {
    logic signed [W:0]   delta_x;
    logic signed [W:0]   delta_y;
    logic signed [W:0]   rel_x;
    logic signed [W:0]   rel_y;
    logic        [2*W:0] dist_sq;
    logic                hovering;
    logic                near;
    logic                dragging;
    logic                left_clicked;
    logic                right_clicked;
    logic signed [W:0]   grab_x;
    logic signed [W:0]   grab_y;
  } pointer_status_t;

  // Register shadow
  logic        drag_en;
  logic [15:0] near_px;
  logic [15:0] drag_px;

  // Interaction state
  logic signed [W-1:0] prev_cx, prev_cy, press_cx, press_cy;
  logic signed [W:0]   grab_dx, grab_dy;
  logic                seen_sample, left_was, right_was;
  logic                press_armed, drag_on, left_click_ev, right_click_ev;

  pointer_status_t status_q[$];
  int              fail_count = 0;

  assign failures_o = fail_count;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic longint square_sum(input longint a, input longint b);
    return a * a + b * b;
  endfunction

  function automatic pointer_status_t classify_sample();
    pointer_status_t st;
    longint cx, cy, bx, by, bw, bh, dx, dy, rx, ry, dsq;
    logic hov;
    st = '0;
    if (in_mon.clear_events) begin
      left_click_ev  = 1'b0;
      right_click_ev = 1'b0;
    end
    if (in_mon.func == FUNC_CANCEL) begin
      press_armed    = 1'b0;
      drag_on        = 1'b0;
      left_click_ev  = 1'b0;
      right_click_ev = 1'b0;
      st.grab_x      = grab_dx;
      st.grab_y      = grab_dy;
      return st;
    end
    cx = in_mon.cursor_x;
    cy = in_mon.cursor_y;
    bx = in_mon.box_x;
    by = in_mon.box_y;
    bw = longint'(in_mon.box_w);
    bh = longint'(in_mon.box_h);
    // first sample after reset reports no movement
    dx = seen_sample ? cx - prev_cx : 0;
    dy = seen_sample ? cy - prev_cy : 0;
    prev_cx     = in_mon.cursor_x;
    prev_cy     = in_mon.cursor_y;
    seen_sample = 1'b1;

    rx  = cx - bx;
    ry  = cy - by;
    dsq = square_sum(cx - (bx + bw / 2), cy - (by + bh / 2));
    if (dsq > DIST_MAX) dsq = DIST_MAX;
    hov = (rx >= 0) && (rx < bw) && (ry >= 0) && (ry < bh);

    if (drag_en) begin
      if (in_mon.left_down) begin
        if (!left_was && !drag_on && hov && !press_armed) begin
          press_armed = 1'b1;
          press_cx    = in_mon.cursor_x;
          press_cy    = in_mon.cursor_y;
          grab_dx     = rx[W:0];
          grab_dy     = ry[W:0];
        end else if (press_armed && !drag_on) begin
          if (square_sum(cx - press_cx, cy - press_cy) >=
              longint'(drag_px) * longint'(drag_px))
            drag_on = 1'b1;
        end
      end else begin
        // release without a drag counts as a click
        if (press_armed && !drag_on) left_click_ev = 1'b1;
        drag_on     = 1'b0;
        press_armed = 1'b0;
      end
    end
    if (!in_mon.right_down && right_was && hov) right_click_ev = 1'b1;
    left_was  = in_mon.left_down;
    right_was = in_mon.right_down;

    st.delta_x       = dx[W:0];
    st.delta_y       = dy[W:0];
    st.rel_x         = rx[W:0];
    st.rel_y         = ry[W:0];
    st.dist_sq       = dsq[2*W:0];
    st.hovering      = hov;
    st.near          = dsq <= longint'(near_px) * longint'(near_px);
    st.dragging      = drag_on;
    st.left_clicked  = left_click_ev;
    st.right_clicked = right_click_ev;
    st.grab_x        = grab_dx;
    st.grab_y        = grab_dy;
    return st;
  endfunction

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
  endtask

  task automatic compare_status(input pointer_status_t want);
    check_field("delta_x", out_mon.delta_x, want.delta_x);
    check_field("delta_y", out_mon.delta_y, want.delta_y);
    check_field("rel_x", out_mon.rel_x, want.rel_x);
    check_field("rel_y", out_mon.rel_y, want.rel_y);
    check_field("dist_sq", out_mon.dist_sq, want.dist_sq);
    check_field("hovering", out_mon.hovering, want.hovering);
    check_field("near", out_mon.near, want.near);
    check_field("dragging", out_mon.dragging, want.dragging);
    check_field("left_clicked", out_mon.left_clicked, want.left_clicked);
    check_field("right_clicked", out_mon.right_clicked, want.right_clicked);
    check_field("grab_x", out_mon.grab_x, want.grab_x);
    check_field("grab_y", out_mon.grab_y, want.grab_y);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_en        = DRAG_ENABLE_RESET;
      near_px        = PROXIMITY_RESET;
      drag_px        = DRAG_THRESHOLD_RESET;
      prev_cx        = '0;
      prev_cy        = '0;
      press_cx       = '0;
      press_cy       = '0;
      grab_dx        = '0;
      grab_dy        = '0;
      seen_sample    = 1'b0;
      left_was       = 1'b0;
      right_was      = 1'b0;
      press_armed    = 1'b0;
      drag_on        = 1'b0;
      left_click_ev  = 1'b0;
      right_click_ev = 1'b0;
      status_q.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_IDX_BITS+1:2])
          REG_DRAG_ENABLE:    drag_en = pwdata[0];
          REG_PROXIMITY:      near_px = pwdata[15:0];
          REG_DRAG_THRESHOLD: drag_px = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) status_q.push_back(classify_sample());
      if (out_mon.valid && out_mon.ready) begin
        if (status_q.size() == 0) report_mismatch("result with no sample outstanding");
        else compare_status(status_q.pop_front());
      end
      pending_o <= status_q.size();
    end
  end

endmodule

[bench/pointer_click_drag_classifier_test.sv]
`timescale 1ns / 1ps
// Bench top for the pointer click/drag classifier: drives samples, result
// stalls and register writes, and reports the verdict from the scoreboard.
// Depends on pccd_pkg, pccd_in_if, pccd_out_if and pccd_scoreboard.
module pointer_click_drag_classifier_test;
  import pccd_pkg::*;

  localparam int     COORD_BITS       = 16;
  localparam int     WB               = COORD_BITS - 1;
  localparam int     CLK_PERIOD       = 10;
  localparam int     LONG_HOLD_CYCLES = 120;
  localparam int     DRAIN_CYCLES     = 4;
  localparam longint RUN_LIMIT_NS     = 2_000_000;

  typedef struct {
    logic                         func;
    logic signed [COORD_BITS-1:0] cursor_x;
    logic signed [COORD_BITS-1:0] cursor_y;
    logic                         left_down;
    logic                         right_down;
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic        [COORD_BITS-2:0] box_w;
    logic        [COORD_BITS-2:0] box_h;
    logic                         clear_events;
  } pointer_item_t;

  logic                     clk_i  = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel, penable, pwrite, pready;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata, prdata;

  int failures;
  int pending;
  int items_sent   = 0;
  bit idle_en      = 1'b1;
  bit hold_request = 1'b0;

  // Target rectangle of the gesture in progress
  int gbx, gby, gbw, gbh;

  pccd_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  pccd_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  pointer_click_drag_classifier #(.COORD_BITS(COORD_BITS)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pccd_scoreboard #(.COORD_BITS(COORD_BITS)) scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .failures_o (failures),
    .pending_o  (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("run limit reached with %0d results outstanding", pending);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, one long hold on request
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  function automatic bit pick_clear();
    return $urandom_range(0, 11) == 0;
  endfunction

  function automatic pointer_item_t random_item();
    pointer_item_t it;
    it.func         = ($urandom_range(0, 7) == 0) ? FUNC_CANCEL : FUNC_SAMPLE;
    it.cursor_x     = COORD_BITS'($urandom());
    it.cursor_y     = COORD_BITS'($urandom());
    it.left_down    = 1'($urandom_range(0, 1));
    it.right_down   = 1'($urandom_range(0, 1));
    it.box_x        = COORD_BITS'($urandom());
    it.box_y        = COORD_BITS'($urandom());
    it.box_w        = WB'($urandom());
    it.box_h        = WB'($urandom());
    it.clear_events = pick_clear();
    return it;
  endfunction

  // Call at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_item(input pointer_item_t it);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= it.func;
    in_ch.cursor_x     <= it.cursor_x;
    in_ch.cursor_y     <= it.cursor_y;
    in_ch.left_down    <= it.left_down;
    in_ch.right_down   <= it.right_down;
    in_ch.box_x        <= it.box_x;
    in_ch.box_y        <= it.box_y;
    in_ch.box_w        <= it.box_w;
    in_ch.box_h        <= it.box_h;
    in_ch.clear_events <= it.clear_events;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_sample(input int cx, input int cy, input bit ld, input bit rd,
                             input bit clr);
    pointer_item_t it;
    it.func         = FUNC_SAMPLE;
    it.cursor_x     = COORD_BITS'(cx);
    it.cursor_y     = COORD_BITS'(cy);
    it.left_down    = ld;
    it.right_down   = rd;
    it.box_x        = COORD_BITS'(gbx);
    it.box_y        = COORD_BITS'(gby);
    it.box_w        = WB'(gbw);
    it.box_h        = WB'(gbh);
    it.clear_events = clr;
    send_item(it);
  endtask

  task automatic send_cancel(input bit clr);
    pointer_item_t it;
    it              = random_item();
    it.func         = FUNC_CANCEL;
    it.clear_events = clr;
    send_item(it);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input logic en, input logic [15:0] prox,
                                input logic [15:0] thr);
    drain_results();
    write_register(REG_DRAG_ENABLE, {31'd0, en});
    write_register(REG_PROXIMITY, {16'd0, prox});
    write_register(REG_DRAG_THRESHOLD, {16'd0, thr});
  endtask

  // Mostly press/move/release and right click gestures on a random box,
  // with cancels, clears and fully random items mixed in.
  task automatic run_gestures(input int count);
    int stop_at, cx, cy, span;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      gbx  = int'($urandom_range(0, 2000)) - 1000;
      gby  = int'($urandom_range(0, 2000)) - 1000;
      gbw  = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 300));
      gbh  = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 300));
      cx   = gbx + ((gbw > 0) ? int'($urandom_range(0, gbw - 1)) : 0);
      cy   = gby + ((gbh > 0) ? int'($urandom_range(0, gbh - 1)) : 0);
      span = ($urandom_range(0, 3) == 0) ? 64 : 8;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          send_sample(cx, cy, 1'b0, 1'b0, pick_clear());
          send_sample(cx, cy, 1'b1, $urandom_range(0, 5) == 0, pick_clear());
          repeat ($urandom_range(0, 6)) begin
            cx += int'($urandom_range(0, 2 * span)) - span;
            cy += int'($urandom_range(0, 2 * span)) - span;
            if ($urandom_range(0, 11) == 0) send_cancel(pick_clear());
            else send_sample(cx, cy, 1'b1, 1'b0, pick_clear());
          end
          send_sample(cx, cy, 1'b0, 1'b0, pick_clear());
        end
        5, 6, 7: begin
          send_sample(cx, cy, 1'b0, 1'b1, pick_clear());
          // sometimes leave the box before letting go
          if ($urandom_range(0, 2) == 0) begin
            cx += int'($urandom_range(0, 2 * span)) - span;
            cy += int'($urandom_range(0, 2 * span)) - span;
          end
          send_sample(cx, cy, $urandom_range(0, 3) == 0, 1'b0, pick_clear());
        end
        default: begin
          repeat ($urandom_range(1, 3)) send_item(random_item());
        end
      endcase
    end
  endtask

  initial begin : stimulus
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_SAMPLE;
    in_ch.cursor_x     <= '0;
    in_ch.cursor_y     <= '0;
    in_ch.left_down    <= 1'b0;
    in_ch.right_down   <= 1'b0;
    in_ch.box_x        <= '0;
    in_ch.box_y        <= '0;
    in_ch.box_w        <= '0;
    in_ch.box_h        <= '0;
    in_ch.clear_events <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset register values
    gbx = 100; gby = 100; gbw = 50; gbh = 40;
    send_sample(10, 20, 1'b0, 1'b0, 1'b0);     // first sample: no delta
    send_sample(120, 110, 1'b1, 1'b0, 1'b0);   // press inside
    send_sample(121, 111, 1'b1, 1'b0, 1'b0);   // below threshold
    send_sample(121, 111, 1'b0, 1'b0, 1'b0);   // release: left click
    send_sample(130, 120, 1'b0, 1'b1, 1'b1);   // clear, right down
    send_sample(131, 120, 1'b0, 1'b0, 1'b0);   // right release while hovering
    send_sample(110, 105, 1'b1, 1'b0, 1'b0);
    send_sample(120, 115, 1'b1, 1'b0, 1'b0);   // drag starts
    send_sample(149, 139, 1'b1, 1'b0, 1'b0);
    send_sample(160, 150, 1'b0, 1'b0, 1'b0);   // release after drag: no click
    send_sample(101, 101, 1'b1, 1'b0, 1'b0);
    send_cancel(1'b0);                         // drop tracking mid-press
    send_sample(101, 101, 1'b1, 1'b0, 1'b0);   // still held: no new press
    send_sample(101, 101, 1'b0, 1'b1, 1'b0);
    send_sample(300, 300, 1'b0, 1'b0, 1'b0);   // right release outside
    send_sample(275, 120, 1'b0, 1'b0, 1'b0);   // exactly at proximity
    send_sample(276, 120, 1'b0, 1'b0, 1'b0);   // just beyond
    gbx = 32767; gby = 32767; gbw = 32767; gbh = 32767;
    send_sample(-32768, -32768, 1'b0, 1'b0, 1'b0);  // distance saturates
    gbx = -32768; gby = -32768; gbw = 0; gbh = 0;
    send_sample(32767, 32767, 1'b1, 1'b1, 1'b0);    // largest positive delta
    send_sample(-32768, -32768, 1'b0, 1'b0, 1'b0);  // largest negative delta
    gbx = 5; gby = 5; gbw = 0; gbh = 7;
    send_sample(5, 5, 1'b0, 1'b1, 1'b0);
    send_sample(5, 5, 1'b0, 1'b0, 1'b0);            // empty box never hovers
    gbx = 0; gby = 0; gbw = 1; gbh = 1;
    send_sample(0, 0, 1'b0, 1'b1, 1'b0);
    send_sample(0, 0, 1'b0, 1'b0, 1'b0);            // one-pixel box click
    send_cancel(1'b1);

    // Random part over several register settings
    apply_settings(1'b1, 16'hFFFF, 16'd0);
    run_gestures(350);
    apply_settings(1'b0, 16'd0, 16'hFFFF);
    run_gestures(300);
    apply_settings(1'b1, 16'($urandom_range(1, 65534)), 16'($urandom_range(1, 30)));
    hold_request = 1'b1;    // back up the result side while samples keep coming
    run_gestures(400);
    apply_settings(1'b1, 16'($urandom_range(0, 400)), 16'($urandom_range(2, 12)));
    idle_en = 1'b0;
    run_gestures(450);
    drain_results();

    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
